FILE: rtl/glycopeptide_mass_pair_search_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the glycopeptide mass pair search.
// Each macro expands to one labeled concurrent assertion on the block clock.
// ----------------------------------------------------------------------------
`ifndef GLYCOPEPTIDE_MASS_PAIR_SEARCH_DEFINES_SVH
`define GLYCOPEPTIDE_MASS_PAIR_SEARCH_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define GMPS_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define GMPS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/gmps_pkg.sv
// ----------------------------------------------------------------------------
// gmps_pkg
// Types and constants shared by the mass pair search controller, datapath
// and top level.
// ----------------------------------------------------------------------------
package gmps_pkg;

   localparam int PEP_DEPTH      = 1024;
   localparam int GLY_DEPTH      = 256;
   localparam int MAX_HITS       = 64;
   localparam int MASS_FRAC_BITS = 16;

   localparam int PEP_AW   = $clog2(PEP_DEPTH);
   localparam int GLY_AW   = $clog2(GLY_DEPTH);
   localparam int MASS_W   = 30;
   localparam int ERR_W    = 24;
   localparam int MAG_W    = 32;
   localparam int SCALE_W  = 20;
   localparam int PROD_W   = MAG_W + SCALE_W;
   localparam int FRAC_SH  = ERR_W - MASS_FRAC_BITS;
   localparam int DIV_W    = $clog2(ERR_W);
   localparam int TOTAL_W  = $clog2(MAX_HITS + 2);
   localparam int ENTRY_W  = MASS_W + 2;

   localparam logic [SCALE_W-1:0] PPM_SCALE = 20'd1000000;

   // Operation codes of an input item.
   localparam logic [1:0] OP_LOAD_PEP = 2'd0;
   localparam logic [1:0] OP_LOAD_GLY = 2'd1;
   localparam logic [1:0] OP_QUERY    = 2'd2;
   localparam logic [1:0] OP_UNUSED   = 2'd3;

   // Configuration register indexes.
   localparam logic [2:0] CSR_TOLERANCE = 3'd0;
   localparam logic [2:0] CSR_USE_PPM   = 3'd1;
   localparam logic [2:0] CSR_FILTER    = 3'd2;
   localparam logic [2:0] CSR_BEST_ONLY = 3'd3;
   localparam logic [2:0] CSR_PEP_COUNT = 3'd4;
   localparam logic [2:0] CSR_GLY_COUNT = 3'd5;
   localparam logic [2:0] CSR_WATER     = 3'd6;

   // Glycan class filter codes.
   localparam logic [1:0] FILT_NONE       = 2'd0;
   localparam logic [1:0] FILT_SIALYL     = 2'd1;
   localparam logic [1:0] FILT_NON_SIALYL = 2'd2;

   typedef struct packed {
      logic [1:0]  operation;
      logic [9:0]  entry_index;
      logic [29:0] mass_value;
      logic        entry_decoy;
      logic        has_site;
      logic        has_sialic_acid;
   } req_type;

   typedef struct packed {
      logic        hit;
      logic [9:0]  peptide_slot;
      logic [7:0]  glycan_slot;
      logic [23:0] error_magnitude;
      logic        glycan_decoy;
      logic        peptide_site;
      logic        truncated;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [23:0] tolerance;
      logic        use_ppm;
      logic [1:0]  filter_class;
      logic        best_hit_only;
      logic [10:0] peptide_count;
      logic [8:0]  glycan_count;
      logic [23:0] water_mass;
   } cfg_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic              wr_pep;
      logic              wr_gly;
      logic              start;
      logic              rd;
      logic              mag;
      logic              mul;
      logic              chk;
      logic              div_step;
      logic              eval;
      logic              emit_final;
      logic [PEP_AW-1:0] pep_addr;
      logic [GLY_AW-1:0] gly_addr;
      logic [DIV_W-1:0]  div_idx;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic over;
      logic out_free;
   } sts_type;

endpackage

FILE: rtl/gmps_ctrl.sv
// ----------------------------------------------------------------------------
// gmps_ctrl
// Sequencer of the pair scan: walks peptides and glycans, steps the
// per-pair error pipeline and the divider, and orders the result transfers.
// ----------------------------------------------------------------------------
module gmps_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  gmps_pkg::req_type req_data,
   input  gmps_pkg::cfg_type cfg,
   input  gmps_pkg::sts_type sts,
   output gmps_pkg::cmd_type cmd
);
   import gmps_pkg::*;

   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_READ  = 9'b000000010,
      S_MAG   = 9'b000000100,
      S_MUL   = 9'b000001000,
      S_CHK   = 9'b000010000,
      S_DIV   = 9'b000100000,
      S_EVAL  = 9'b001000000,
      S_NEXT  = 9'b010000000,
      S_FINAL = 9'b100000000
   } state_type;

   state_type         state_ff, state_in;
   logic [PEP_AW-1:0] p_ff, p_in;
   logic [GLY_AW-1:0] g_ff, g_in;
   logic [DIV_W-1:0]  k_ff, k_in;
   logic [10:0]       np;
   logic [8:0]        ng;
   logic              accept;

   // Counts saturate at the table depths.
   assign np = (cfg.peptide_count > 11'(PEP_DEPTH)) ? 11'(PEP_DEPTH) : cfg.peptide_count;
   assign ng = (cfg.glycan_count > 9'(GLY_DEPTH)) ? 9'(GLY_DEPTH) : cfg.glycan_count;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      p_in     = p_ff;
      g_in     = g_ff;
      k_in     = k_ff;
      cmd      = '0;
      cmd.pep_addr = p_ff;
      cmd.gly_addr = g_ff;
      cmd.div_idx  = k_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.wr_pep = (req_data.operation == OP_LOAD_PEP);
               cmd.wr_gly = (req_data.operation == OP_LOAD_GLY);
               if (req_data.operation == OP_QUERY) begin
                  cmd.start = 1'b1;
                  p_in      = '0;
                  g_in      = '0;
                  state_in  = (np != '0 && ng != '0) ? S_READ : S_FINAL;
               end
            end
         end
         S_READ: begin
            cmd.rd   = 1'b1;
            state_in = S_MAG;
         end
         S_MAG: begin
            cmd.mag  = 1'b1;
            state_in = S_MUL;
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = cfg.use_ppm ? S_CHK : S_EVAL;
         end
         S_CHK: begin
            cmd.chk  = 1'b1;
            k_in     = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            if (sts.over) begin
               state_in = S_EVAL;
            end else begin
               cmd.div_step = 1'b1;
               k_in         = k_ff + 1'b1;
               if (k_ff == DIV_W'(ERR_W - 1)) state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            // The evaluation may push a held hit out, so it waits for room.
            if (sts.out_free) begin
               cmd.eval = 1'b1;
               state_in = S_NEXT;
            end
         end
         S_NEXT: begin
            state_in = S_READ;
            if ({1'b0, g_ff} == ng - 1'b1) begin
               g_in = '0;
               if ({1'b0, p_ff} == np - 1'b1) state_in = S_FINAL;
               else p_in = p_ff + 1'b1;
            end else begin
               g_in = g_ff + 1'b1;
            end
         end
         S_FINAL: begin
            if (sts.out_free) begin
               cmd.emit_final = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         p_ff     <= '0;
         g_ff     <= '0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         p_ff     <= p_in;
         g_ff     <= g_in;
         k_ff     <= k_in;
      end
   end

endmodule

FILE: rtl/gmps_datapath.sv
// ----------------------------------------------------------------------------
// gmps_datapath
// Peptide and glycan tables, pair error arithmetic with a bit-serial
// divider for ppm errors, best-hit and held-hit tracking, output register.
// ----------------------------------------------------------------------------
module gmps_datapath (
   input  logic              clock,
   input  logic              reset,
   input  gmps_pkg::req_type req_data,
   input  gmps_pkg::cfg_type cfg,
   input  gmps_pkg::cmd_type cmd,
   output gmps_pkg::sts_type sts,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output gmps_pkg::rsp_type rsp_data
);
   import gmps_pkg::*;

   logic [ENTRY_W-1:0] pep_mem [PEP_DEPTH];
   logic [ENTRY_W-1:0] gly_mem [GLY_DEPTH];

   logic [ENTRY_W-1:0] pe_ff, ge_ff;
   logic [MASS_W-1:0]  q_ff;
   logic [MAG_W-1:0]   mag_ff;
   logic               pass_ff;
   logic [PROD_W-1:0]  prod_ff;
   logic               over_ff;
   logic [MASS_W-1:0]  rem_ff;
   logic [ERR_W-1:0]   quo_ff;
   logic               found_ff;
   rsp_type            best_ff;
   rsp_type            pend_ff;
   logic               pend_valid_ff;
   logic [TOTAL_W-1:0] total_ff;
   logic               out_valid_ff;
   rsp_type            out_ff;

   logic [MAG_W:0]     diff;
   logic [MAG_W-1:0]   mag_in;
   logic               pass_in;
   logic               div_bit;
   logic [MASS_W:0]    trial;
   logic               err_ok;
   logic [ERR_W-1:0]   err_val;
   logic               pair_hit;
   rsp_type            cur;
   rsp_type            nomatch;
   rsp_type            final_rsp;
   logic               keep_hit;
   logic               held_out;
   logic               out_free;

   // Table writes; an out-of-range index is dropped.
   always_ff @(posedge clock) begin
      if (cmd.wr_pep && 32'(req_data.entry_index) < PEP_DEPTH)
         pep_mem[req_data.entry_index[PEP_AW-1:0]] <=
            {req_data.has_site, req_data.entry_decoy, req_data.mass_value};
      if (cmd.wr_gly && 32'(req_data.entry_index) < GLY_DEPTH)
         gly_mem[req_data.entry_index[GLY_AW-1:0]] <=
            {req_data.has_sialic_acid, req_data.entry_decoy, req_data.mass_value};
      if (cmd.rd) begin
         pe_ff <= pep_mem[cmd.pep_addr];
         ge_ff <= gly_mem[cmd.gly_addr];
      end
   end

   // Signed mass difference and its magnitude.
   assign diff = (MAG_W+1)'(pe_ff[MASS_W-1:0]) + (MAG_W+1)'(ge_ff[MASS_W-1:0])
               - (MAG_W+1)'(cfg.water_mass) - (MAG_W+1)'(q_ff);
   assign mag_in = diff[MAG_W] ? MAG_W'(-diff) : diff[MAG_W-1:0];

   // Class filter applies only to pairs with no decoy.
   always_comb begin
      pass_in = 1'b1;
      if ((cfg.filter_class == FILT_SIALYL || cfg.filter_class == FILT_NON_SIALYL)
          && !pe_ff[MASS_W] && !ge_ff[MASS_W])
         pass_in = ((cfg.filter_class == FILT_SIALYL) == ge_ff[MASS_W+1]);
   end

   // Dividend bit brought in by each divider step.
   always_comb begin
      div_bit = 1'b0;
      if (32'(cmd.div_idx) < FRAC_SH)
         div_bit = prod_ff[FRAC_SH - 1 - 32'(cmd.div_idx)];
   end
   assign trial = {rem_ff, div_bit};

   // Error value and hit decision of the current pair.
   always_comb begin
      if (cfg.use_ppm) begin
         err_ok  = !over_ff;
         err_val = quo_ff;
      end else begin
         err_ok  = (mag_ff[MAG_W-1:ERR_W] == '0);
         err_val = mag_ff[ERR_W-1:0];
      end
      pair_hit = pass_ff && err_ok && (err_val <= cfg.tolerance);
   end

   always_comb begin
      cur                 = '0;
      cur.hit             = 1'b1;
      cur.peptide_slot    = 10'(cmd.pep_addr);
      cur.glycan_slot     = 8'(cmd.gly_addr);
      cur.error_magnitude = err_val;
      cur.glycan_decoy    = ge_ff[MASS_W];
      cur.peptide_site    = pe_ff[MASS_W+1];
      nomatch             = '0;
      nomatch.last        = 1'b1;
   end

   // Closing result of a query: the best pair, the held hit or a no-match.
   always_comb begin
      final_rsp = nomatch;
      if (cfg.best_hit_only) begin
         if (found_ff) begin
            final_rsp      = best_ff;
            final_rsp.last = 1'b1;
         end
      end else if (pend_valid_ff) begin
         final_rsp           = pend_ff;
         final_rsp.last      = 1'b1;
         final_rsp.truncated = (32'(total_ff) > MAX_HITS);
      end
   end

   // In all-hits mode a kept hit is held; the one held before it goes out.
   assign keep_hit = cmd.eval && pair_hit && !cfg.best_hit_only
                     && (32'(total_ff) < MAX_HITS);
   assign held_out = keep_hit && pend_valid_ff;

   assign out_free = !out_valid_ff || !rsp_stall;

   // Pair pipeline registers.
   always_ff @(posedge clock) begin
      if (cmd.start) q_ff <= req_data.mass_value;
      if (cmd.mag) begin
         mag_ff  <= mag_in;
         pass_ff <= pass_in;
      end
      if (cmd.mul) prod_ff <= PROD_W'(mag_ff) * PROD_W'(PPM_SCALE);
      if (cmd.chk) begin
         over_ff <= (q_ff == '0) || (prod_ff >= PROD_W'({q_ff, FRAC_SH'(0)}));
         rem_ff  <= MASS_W'(prod_ff >> FRAC_SH);
         quo_ff  <= '0;
      end
      if (cmd.div_step) begin
         if (trial >= (MASS_W+1)'(q_ff)) begin
            rem_ff <= MASS_W'(trial - (MASS_W+1)'(q_ff));
            quo_ff <= {quo_ff[ERR_W-2:0], 1'b1};
         end else begin
            rem_ff <= trial[MASS_W-1:0];
            quo_ff <= {quo_ff[ERR_W-2:0], 1'b0};
         end
      end
   end

   // Hit tracking and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff      <= 1'b0;
         pend_valid_ff <= 1'b0;
         total_ff      <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (cmd.emit_final) begin
            out_ff       <= final_rsp;
            out_valid_ff <= 1'b1;
         end else if (held_out) begin
            out_ff       <= pend_ff;
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end

         if (cmd.start || cmd.emit_final) pend_valid_ff <= 1'b0;
         else if (keep_hit) pend_valid_ff <= 1'b1;
         if (keep_hit) pend_ff <= cur;

         if (cmd.start) begin
            found_ff <= 1'b0;
            total_ff <= '0;
         end else if (cmd.eval && pair_hit) begin
            if (cfg.best_hit_only) begin
               if (!found_ff || err_val < best_ff.error_magnitude) begin
                  found_ff <= 1'b1;
                  best_ff  <= cur;
               end
            end else if (32'(total_ff) <= MAX_HITS) begin
               total_ff <= total_ff + 1'b1;
            end
         end
      end
   end

   assign sts.over     = over_ff;
   assign sts.out_free = out_free;
   assign rsp_valid    = out_valid_ff;
   assign rsp_data     = out_ff;

endmodule

FILE: rtl/glycopeptide_mass_pair_search.sv
// ----------------------------------------------------------------------------
// glycopeptide_mass_pair_search
// Precursor mass search over all peptide and glycan pairs with ppm or
// dalton tolerance, best-hit or all-hits reporting.
// ----------------------------------------------------------------------------
// A load is written to its table when it is accepted. A query scans peptides
// (outer) and glycans (inner) one pair at a time: each pair is read, its
// error magnitude formed and multiplied, and the pair evaluated; in ppm mode
// a range check and a one-bit-per-cycle divider that forms the 24-bit error
// come before the evaluation, and a ppm pair whose error is already out of
// range skips the divider. The evaluation of a pair and the closing result
// wait while the result side is stalling. The block takes no new item while
// a query scan is running.
module glycopeptide_mass_pair_search (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  gmps_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output gmps_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [2:0]        csr_index,
   input  logic [23:0]       csr_data
);
   import gmps_pkg::*;

`include "glycopeptide_mass_pair_search_defines.svh"

   cfg_type cfg_ff;
   cmd_type cmd;
   sts_type sts;

   // Configuration registers; writes are always taken.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tolerance     <= 24'(20 << MASS_FRAC_BITS);
         cfg_ff.use_ppm       <= 1'b1;
         cfg_ff.filter_class  <= FILT_NONE;
         cfg_ff.best_hit_only <= 1'b1;
         cfg_ff.peptide_count <= '0;
         cfg_ff.glycan_count  <= '0;
         cfg_ff.water_mass    <= 24'(((64'd1801056 << MASS_FRAC_BITS) + 64'd50000) / 64'd100000);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_TOLERANCE: cfg_ff.tolerance     <= csr_data;
            CSR_USE_PPM:   cfg_ff.use_ppm       <= csr_data[0];
            CSR_FILTER:    cfg_ff.filter_class  <= csr_data[1:0];
            CSR_BEST_ONLY: cfg_ff.best_hit_only <= csr_data[0];
            CSR_PEP_COUNT: cfg_ff.peptide_count <= csr_data[10:0];
            CSR_GLY_COUNT: cfg_ff.glycan_count  <= csr_data[8:0];
            CSR_WATER:     cfg_ff.water_mass    <= csr_data;
            default: ;
         endcase
      end
   end

   gmps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .cfg       (cfg_ff),
      .sts       (sts),
      .cmd       (cmd)
   );

   gmps_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cfg       (cfg_ff),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // A query transfer starts a scan, so the input side stalls next cycle.
   `GMPS_ASSERT_NEXT(a_query_busy, req_valid && !req_stall && req_data.operation == OP_QUERY, req_stall, "query did not start a scan")
   // A no-match result always closes its query.
   `GMPS_ASSERT_IMPL(a_nomatch_last, rsp_valid && !rsp_data.hit, rsp_data.last, "no-match result without last")
   // Truncation is flagged only on the closing hit.
   `GMPS_ASSERT_IMPL(a_trunc_last, rsp_valid && rsp_data.truncated, rsp_data.last && rsp_data.hit, "truncated flag on a non-final result")

endmodule
